// ----- sv/rrts_pkg.sv -----
`default_nettype none

package rrts_pkg;

    // command codes
    localparam logic [2:0] CMD_SCHEDULE = 3'd0;
    localparam logic [2:0] CMD_BLOCK    = 3'd1;
    localparam logic [2:0] CMD_UNBLOCK  = 3'd2;
    localparam logic [2:0] CMD_ADD      = 3'd3;
    localparam logic [2:0] CMD_POSTPONE = 3'd4;
    localparam logic [2:0] CMD_RELEASE  = 3'd5;

    // task state codes
    localparam logic [2:0] ST_READY      = 3'd0;
    localparam logic [2:0] ST_RUNNING    = 3'd1;
    localparam logic [2:0] ST_TERMINATED = 3'd2;
    localparam logic [2:0] ST_WAITPID    = 3'd3;
    localparam logic [2:0] ST_SLEEPING   = 3'd4;
    localparam logic [2:0] ST_PAUSED     = 3'd5;
    localparam logic [2:0] ST_WAIT_LOCK  = 3'd6;

    // status codes
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_NOT_BLOCKED = 2'd1;
    localparam logic [1:0] STAT_QUEUED      = 2'd2;
    localparam logic [1:0] STAT_EMPTY       = 2'd3;

    localparam logic [7:0]  PRIO_NO_SLICE  = 8'd255;
    localparam logic [9:0]  SLICE_BASE     = 10'd900;
    localparam int          SLICE_SHIFT    = 16;
    localparam logic [7:0]  TASK0_PRIO     = 8'd128;
    localparam logic [31:0] TASK0_SLICE    = 32'd50000000;
    localparam logic [7:0]  POSTPONE_MAX   = 8'd255;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] task_id;
        logic [2:0] block_reason;
        logic [7:0] priority_req;
    } t_sched_in;

    typedef struct packed {
        logic        switched;
        logic [5:0]  running_task;
        logic [31:0] slice_left;
        logic        deferred;
        logic [1:0]  status;
    } t_sched_out;

endpackage

`default_nettype wire

// ----- sv/rrts_stream_if.sv -----
`default_nettype none

interface rrts_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/rrts_ram.sv -----
`default_nettype none

module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/round_robin_task_scheduler.sv -----
// round-robin task scheduler with a fifo ready queue
//
// i_cmd_chan carries one command word (schedule, block current, unblock, add,
// postpone, release); o_res_chan returns exactly one result word per command:
// switched flag, running task, its slice word, deferred flag and status.
// a taken command waits in the input register until the output register is free
// or being taken; its result is then loaded into the output register and held
// there until the receiver takes it. one command per cycle is sustained while
// the receiver takes every result; the execute step uses the per-task memory
// read, which is issued from the port as the command is taken.
// per-task state/priority/slice live in one ram, ready queue entries in a
// second ram; a queue entry carries the task's priority and slice, so a pop
// needs no second lookup. the current task is held in registers.
// reset: task 0 running with priority 128 and slice 50000000, queue empty,
// no postpone; valid bits make the task ram read as paused/zero until written,
// so no clearing pass is needed and commands are taken right after reset.
// when the receiver stalls, the result waits in the output register, one more
// command is taken into the input register, then i_cmd_chan.ready drops.
`default_nettype none

module round_robin_task_scheduler #(
    parameter int MAX_TASKS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rrts_stream_if.sink   i_cmd_chan,
    rrts_stream_if.source o_res_chan
);

    import rrts_pkg::*;

    localparam int TW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int SW = CW + 1;
    localparam int EW = TW + 40;
    localparam int DW = 43;
    localparam logic [TW-1:0] LAST_ID = TW'(MAX_TASKS - 1);

    function automatic logic [63:0][TW-1:0] build_tid_map();
        logic [63:0][TW-1:0] m;
        for (int i = 0; i < 64; i++) begin
            m[i] = TW'(i % MAX_TASKS);
        end
        return m;
    endfunction

    localparam logic [63:0][TW-1:0] TID_MAP = build_tid_map();

    // input stage
    logic            r_in_vld;
    t_sched_in       r_in;
    logic [TW-1:0]   r_tid;
    logic            fire;
    logic            in_acc;
    logic [TW-1:0]   tid_acc;

    // output stage
    logic            r_out_vld;
    t_sched_out      r_out;
    t_sched_out      n_out;

    // scheduler state
    logic [TW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [TW-1:0]        r_cur, n_cur;
    logic [2:0]           r_cur_state, n_cur_state;
    logic [7:0]           r_cur_prio, n_cur_prio;
    logic [31:0]          r_cur_slice, n_cur_slice;
    logic [7:0]           r_depth, n_depth;
    logic                 r_pending, n_pending;
    logic [MAX_TASKS-1:0] r_queued, n_queued;
    logic [MAX_TASKS-1:0] r_t_valid;

    // task ram: {state, priority, slice}
    logic            t_we;
    logic [TW-1:0]   t_waddr;
    logic [DW-1:0]   t_wdata;
    logic [DW-1:0]   t_rdata;
    logic            r_t_byp;
    logic [DW-1:0]   r_t_byp_data;
    logic            r_t_rd_valid;

    // ring ram: {task id, priority, slice}
    logic            q_we;
    logic [TW-1:0]   q_waddr;
    logic [EW-1:0]   q_wdata;
    logic [EW-1:0]   q_rdata;
    logic            r_q_byp;
    logic [EW-1:0]   r_q_byp_data;

    // execute-stage helpers
    logic [DW-1:0]   t_sel;
    logic            tid_is_cur;
    logic [2:0]      tid_state;
    logic [7:0]      tid_prio;
    logic [31:0]     tid_slice;
    logic [EW-1:0]   hd;
    logic [TW-1:0]   hd_id;
    logic [7:0]      hd_prio;
    logic [31:0]     hd_slice;
    logic [32:0]     slice_sum;
    logic [31:0]     hd_new_slice;
    logic [SW-1:0]   tail_sum;
    logic [TW-1:0]   tail;
    logic            enq;
    logic [EW-1:0]   enq_entry;
    logic            pop;
    logic            do_sched;
    logic [2:0]      cur_st;
    logic [1:0]      status;

    assign fire    = r_in_vld && (!r_out_vld || o_res_chan.ready);
    assign in_acc  = i_cmd_chan.valid && i_cmd_chan.ready;
    assign tid_acc = TID_MAP[i_cmd_chan.data.task_id];

    assign i_cmd_chan.ready = !r_in_vld || fire;
    assign o_res_chan.valid = r_out_vld;
    assign o_res_chan.data  = r_out;

    rrts_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_TASKS)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_re    (in_acc),
        .i_raddr (tid_acc),
        .o_rdata (t_rdata)
    );

    rrts_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TASKS)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (1'b1),
        .i_raddr (n_head),
        .o_rdata (q_rdata)
    );

    // per-task view of the commanded task, current task taken from registers
    always_comb begin
        t_sel = r_t_byp ? r_t_byp_data
              : (r_t_rd_valid ? t_rdata : {ST_PAUSED, 8'd0, 32'd0});
        tid_is_cur = (r_tid == r_cur);
        tid_state  = tid_is_cur ? r_cur_state : t_sel[42:40];
        tid_prio   = tid_is_cur ? r_cur_prio  : t_sel[39:32];
        tid_slice  = tid_is_cur ? r_cur_slice : t_sel[31:0];
    end

    // queue head, its refreshed slice and the ring tail index
    always_comb begin
        hd       = r_q_byp ? r_q_byp_data : q_rdata;
        hd_id    = hd[EW-1 -: TW];
        hd_prio  = hd[39:32];
        hd_slice = hd[31:0];
        slice_sum = {1'b0, hd_slice}
                  + 33'({(SLICE_BASE - {2'b00, hd_prio}), 16'd0});
        if (hd_prio == PRIO_NO_SLICE) begin
            hd_new_slice = 32'd0;
        end else if (slice_sum[32]) begin
            hd_new_slice = '1;
        end else begin
            hd_new_slice = slice_sum[31:0];
        end
        tail_sum = SW'(r_head) + SW'(r_count);
        tail = (tail_sum >= SW'(MAX_TASKS)) ? TW'(tail_sum - SW'(MAX_TASKS)) : TW'(tail_sum);
    end

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_cur       = r_cur;
        n_cur_prio  = r_cur_prio;
        n_cur_slice = r_cur_slice;
        n_depth     = r_depth;
        n_pending   = r_pending;
        n_queued    = r_queued;
        cur_st      = r_cur_state;
        t_we        = 1'b0;
        t_waddr     = r_tid;
        t_wdata     = {ST_READY, r_in.priority_req, tid_slice};
        enq         = 1'b0;
        enq_entry   = {r_tid, tid_prio, tid_slice};
        pop         = 1'b0;
        do_sched    = 1'b0;
        status      = STAT_OK;
        q_we        = 1'b0;
        q_waddr     = tail;
        q_wdata     = enq_entry;

        if (fire) begin
            case (r_in.cmd)
                CMD_SCHEDULE: begin
                    do_sched = 1'b1;
                end
                CMD_BLOCK: begin
                    if (r_in.block_reason < ST_TERMINATED
                        || r_in.block_reason > ST_WAIT_LOCK) begin
                        cur_st = ST_PAUSED;
                    end else begin
                        cur_st = r_in.block_reason;
                    end
                    do_sched = 1'b1;
                end
                CMD_UNBLOCK: begin
                    if (tid_state == ST_READY || tid_state == ST_RUNNING) begin
                        status = STAT_NOT_BLOCKED;
                    end else if (r_queued[r_tid]) begin
                        status = STAT_QUEUED;
                    end else begin
                        enq = 1'b1;
                    end
                end
                CMD_ADD: begin
                    if (r_queued[r_tid]) begin
                        status = STAT_QUEUED;
                    end else begin
                        enq       = 1'b1;
                        enq_entry = {r_tid, r_in.priority_req, tid_slice};
                        if (tid_is_cur) begin
                            cur_st     = ST_READY;
                            n_cur_prio = r_in.priority_req;
                        end else begin
                            t_we = 1'b1;
                        end
                    end
                end
                CMD_POSTPONE: begin
                    if (r_depth != POSTPONE_MAX) begin
                        n_depth = r_depth + 8'd1;
                    end
                end
                CMD_RELEASE: begin
                    if (r_depth != 8'd0) begin
                        n_depth = r_depth - 8'd1;
                        if (r_depth == 8'd1 && r_pending) begin
                            n_pending = 1'b0;
                            do_sched  = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (do_sched) begin
                if (n_depth != 8'd0) begin
                    n_pending = 1'b1;
                end else if (r_count == '0) begin
                    status = STAT_EMPTY;
                end else begin
                    if (cur_st == ST_RUNNING) begin
                        cur_st = ST_READY;
                        if (!r_queued[r_cur]) begin
                            enq       = 1'b1;
                            enq_entry = {r_cur, r_cur_prio, r_cur_slice};
                        end
                    end
                    pop = 1'b1;
                    // old current goes back to the task ram
                    t_we        = 1'b1;
                    t_waddr     = r_cur;
                    t_wdata     = {cur_st, r_cur_prio, r_cur_slice};
                    n_cur       = hd_id;
                    cur_st      = ST_RUNNING;
                    n_cur_prio  = hd_prio;
                    n_cur_slice = hd_new_slice;
                end
            end

            if (enq && r_count < CW'(MAX_TASKS)) begin
                q_we     = 1'b1;
                q_wdata  = enq_entry;
                n_queued[enq_entry[EW-1 -: TW]] = 1'b1;
            end
            if (pop) begin
                n_queued[hd_id] = 1'b0;
                n_head = (r_head == LAST_ID) ? '0 : r_head + TW'(1);
            end
            n_count = r_count + CW'(q_we) - CW'(pop);
        end

        n_cur_state = cur_st;

        n_out.switched     = pop;
        n_out.running_task = 6'(n_cur);
        n_out.slice_left   = n_cur_slice;
        n_out.deferred     = n_pending;
        n_out.status       = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
            r_cur       <= '0;
            r_cur_state <= ST_RUNNING;
            r_cur_prio  <= TASK0_PRIO;
            r_cur_slice <= TASK0_SLICE;
            r_depth     <= '0;
            r_pending   <= 1'b0;
            r_queued    <= '0;
            r_t_valid   <= '0;
            r_q_byp     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_res_chan.ready) begin
                r_out_vld <= 1'b0;
            end
            r_head      <= n_head;
            r_count     <= n_count;
            r_cur       <= n_cur;
            r_cur_state <= n_cur_state;
            r_cur_prio  <= n_cur_prio;
            r_cur_slice <= n_cur_slice;
            r_depth     <= n_depth;
            r_pending   <= n_pending;
            r_queued    <= n_queued;
            if (t_we) begin
                r_t_valid[t_waddr] <= 1'b1;
            end
            // the registered ring read misses a write to the same address, so bypass it
            r_q_byp <= q_we && (q_waddr == n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_byp_data <= q_wdata;
        if (fire) begin
            r_out <= n_out;
        end
        if (in_acc) begin
            r_in         <= i_cmd_chan.data;
            r_tid        <= tid_acc;
            r_t_byp      <= t_we && (t_waddr == tid_acc);
            r_t_byp_data <= t_wdata;
            r_t_rd_valid <= r_t_valid[tid_acc] || (t_we && (t_waddr == tid_acc));
        end
    end

endmodule

`default_nettype wire
